@@ rtl/core/dll_pkg.sv @@
// ----------------------------------------------------------------------------
// dll_pkg
// Shared codes, types and defaults for the linked list pool.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int NodeSlotsDef = 64;
  localparam int ScanW        = 8;
  localparam int ScanBits     = 3;

  localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_DELETE     = 3'd4;
  localparam logic [2:0] REQ_KTH        = 3'd5;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FULL       = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN,
    OP_PUSH_W1,
    OP_PUSH_W2,
    OP_RD_NODE,
    OP_UNLINK,
    OP_WALK_RD,
    OP_WALK_ADV,
    OP_VAL_RD,
    OP_RES_NODE,
    OP_RES_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] err;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       free_hit;
    logic       scan_end;
    logic       is_empty;
    logic       bad_handle;
    logic       pos_bad;
    logic       walk_done;
    logic       cur_null;
    logic       out_busy;
  } dp_stat_t;

endpackage

@@ rtl/core/doubly_linked_list_pool.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_list_pool
// Doubly linked list of signed 32-bit values in a pool of node slots.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    req_type, value, node_handle, position
// out      output     out_valid / out_ready  status, result_handle, result_value
//
// One request at a time. Push scans 8-slot groups for the lowest free slot,
// then writes the node and links it. Pop and delete read the node, then unlink
// it. Kth follows links from the head. A full pool is rejected once every
// group has been scanned.
// Reset clears the in-use bits and the list registers; node memories need none.
// A result waits in the output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module doubly_linked_list_pool
  import dll_pkg::*;
#(
  parameter int NODE_SLOTS = NodeSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_node_handle,
  input  logic [6:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_result_handle,
  output logic [31:0] out_result_value
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dll_datapath #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_value          (in_value),
    .in_node_handle    (in_node_handle),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_result_handle (out_result_handle),
    .out_result_value  (out_result_value)
  );

endmodule

@@ rtl/core/dll_datapath.sv @@
// ----------------------------------------------------------------------------
// dll_datapath
// Node memories, list registers, free-slot scan and result register.
// ----------------------------------------------------------------------------
module dll_datapath
  import dll_pkg::*;
#(
  parameter int NODE_SLOTS = NodeSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_value,
  input  logic [5:0]  in_node_handle,
  input  logic [6:0]  in_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_result_handle,
  output logic [31:0] out_result_value
);

  localparam int IW = $clog2(NODE_SLOTS);
  localparam int LW = $clog2(NODE_SLOTS + 1);
  localparam int CW = (LW > 7) ? LW : 7;
  localparam int NG = (NODE_SLOTS + ScanW - 1) / ScanW;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [LW-1:0] NullSlot = LW'(NODE_SLOTS);

  logic [31:0]     mem_val [NODE_SLOTS];
  logic [LW-1:0]   mem_nxt [NODE_SLOTS];
  logic [LW-1:0]   mem_prv [NODE_SLOTS];

  logic [2:0]      req_r;
  logic [31:0]     val_r;
  logic [5:0]      hnd_r;
  logic [6:0]      pos_r;
  logic [6:0]      i_r;
  logic [LW-1:0]   cur_r, head_r, tail_r, cnt_r;
  logic [GW-1:0]   grp_r;
  logic [NODE_SLOTS-1:0] in_use_r;
  logic [31:0]     val_q;
  logic [LW-1:0]   nxt_q, prv_q;

  logic            out_valid_r;
  logic [2:0]      out_status_r;
  logic [5:0]      out_handle_r;
  logic [31:0]     out_value_r;
  logic            out_load;

  logic [NG*ScanW-1:0] used_pad;
  logic [ScanW-1:0]    grp_used;
  logic [ScanBits-1:0] hit_j;
  logic                hit;
  logic [GW+ScanBits-1:0] hit_idx;

  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            wv_en, wn_en, wp_en;
  logic [IW-1:0]   wn_addr, wp_addr;
  logic [LW-1:0]   wn_data, wp_data;
  logic            head_null;

  assign head_null = (head_r == NullSlot);
  assign out_load  = cmd.op inside {OP_PUSH_W2, OP_UNLINK, OP_RES_NODE, OP_RES_ERR};

  always_comb begin
    used_pad = '1;
    used_pad[NODE_SLOTS-1:0] = in_use_r;
    grp_used = used_pad[{grp_r, {ScanBits{1'b0}}} +: ScanW];
    hit   = 1'b0;
    hit_j = '0;
    for (int j = ScanW - 1; j >= 0; j--) begin
      if (!grp_used[j]) begin
        hit   = 1'b1;
        hit_j = ScanBits'(j);
      end
    end
    hit_idx = {grp_r, hit_j};
  end

  always_comb begin
    stat.req        = req_r;
    stat.free_hit   = hit;
    stat.scan_end   = (grp_r == GW'(NG - 1));
    stat.is_empty   = (req_r == REQ_POP_FRONT) ? head_null : (tail_r == NullSlot);
    stat.bad_handle = (CW'(hnd_r) >= CW'(NODE_SLOTS)) ? 1'b1 : !in_use_r[IW'(hnd_r)];
    stat.pos_bad    = (pos_r == 7'd0) || (CW'(pos_r) > CW'(cnt_r));
    stat.walk_done  = (i_r == pos_r);
    stat.cur_null   = (cur_r == NullSlot);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_r[IW-1:0];
    wv_en   = 1'b0;
    wn_en   = 1'b0;
    wp_en   = 1'b0;
    wn_addr = cur_r[IW-1:0];
    wp_addr = cur_r[IW-1:0];
    wn_data = NullSlot;
    wp_data = NullSlot;
    case (cmd.op)
      OP_RD_NODE, OP_WALK_RD, OP_VAL_RD: begin
        rd_en = 1'b1;
      end
      OP_PUSH_W1: begin
        wv_en   = 1'b1;
        wn_en   = 1'b1;
        wp_en   = 1'b1;
        wn_data = (head_null || req_r == REQ_PUSH_BACK) ? NullSlot : head_r;
        wp_data = (head_null || req_r == REQ_PUSH_FRONT) ? NullSlot : tail_r;
      end
      OP_PUSH_W2: begin
        if (!head_null) begin
          if (req_r == REQ_PUSH_BACK) begin
            wn_en   = 1'b1;
            wn_addr = tail_r[IW-1:0];
            wn_data = cur_r;
          end else begin
            wp_en   = 1'b1;
            wp_addr = head_r[IW-1:0];
            wp_data = cur_r;
          end
        end
      end
      OP_UNLINK: begin
        wn_en   = (prv_q != NullSlot);
        wn_addr = prv_q[IW-1:0];
        wn_data = nxt_q;
        wp_en   = (nxt_q != NullSlot);
        wp_addr = nxt_q[IW-1:0];
        wp_data = prv_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wv_en) mem_val[cur_r[IW-1:0]] <= val_r;
    if (wn_en) mem_nxt[wn_addr] <= wn_data;
    if (wp_en) mem_prv[wp_addr] <= wp_data;
    if (rd_en) begin
      val_q <= mem_val[rd_addr];
      nxt_q <= mem_nxt[rd_addr];
      prv_q <= mem_prv[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_r <= in_req_type;
        val_r <= in_value;
        hnd_r <= in_node_handle;
        pos_r <= in_position;
        i_r   <= 7'd1;
        case (in_req_type)
          REQ_POP_BACK: cur_r <= tail_r;
          REQ_DELETE:   cur_r <= LW'(in_node_handle);
          default:      cur_r <= head_r;
        endcase
      end
      OP_SCAN: begin
        if (hit) cur_r <= LW'(hit_idx);
      end
      OP_WALK_ADV: begin
        cur_r <= nxt_q;
        i_r   <= i_r + 7'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= '0;
      in_use_r    <= '0;
      head_r      <= NullSlot;
      tail_r      <= NullSlot;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_LOAD: grp_r <= '0;
        OP_SCAN: begin
          if (!hit && !stat.scan_end) grp_r <= grp_r + GW'(1);
        end
        OP_PUSH_W1: in_use_r[cur_r[IW-1:0]] <= 1'b1;
        OP_PUSH_W2: begin
          if (head_null) begin
            head_r <= cur_r;
            tail_r <= cur_r;
          end else if (req_r == REQ_PUSH_BACK) begin
            tail_r <= cur_r;
          end else begin
            head_r <= cur_r;
          end
          cnt_r        <= cnt_r + LW'(1);
          out_status_r <= ST_OK;
          out_handle_r <= 6'(cur_r);
          out_value_r  <= val_r;
        end
        OP_UNLINK: begin
          if (prv_q == NullSlot) head_r <= nxt_q;
          if (nxt_q == NullSlot) tail_r <= prv_q;
          in_use_r[cur_r[IW-1:0]] <= 1'b0;
          if (cnt_r != '0) cnt_r <= cnt_r - LW'(1);
          out_status_r <= ST_OK;
          out_handle_r <= 6'(cur_r);
          out_value_r  <= val_q;
        end
        OP_RES_NODE: begin
          out_status_r <= ST_OK;
          out_handle_r <= 6'(cur_r);
          out_value_r  <= val_q;
        end
        OP_RES_ERR: begin
          out_status_r <= cmd.err;
          out_handle_r <= '0;
          out_value_r  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;
  assign out_result_value  = out_value_r;

endmodule

@@ rtl/core/dll_ctrl.sv @@
// ----------------------------------------------------------------------------
// dll_ctrl
// Request sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
module dll_ctrl
  import dll_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_PUSH_W1,
    S_PUSH_W2,
    S_UNLINK,
    S_WALK,
    S_WALK_ADV,
    S_RES_NODE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    cmd.err   = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req)
          REQ_PUSH_BACK, REQ_PUSH_FRONT: state_nxt = S_SCAN;
          REQ_POP_FRONT, REQ_POP_BACK: begin
            if (!stat.is_empty) begin
              cmd.op    = OP_RD_NODE;
              state_nxt = S_UNLINK;
            end else if (!stat.out_busy) begin
              cmd.op    = OP_RES_ERR;
              cmd.err   = ST_EMPTY;
              state_nxt = S_IDLE;
            end
          end
          REQ_DELETE: begin
            if (!stat.bad_handle) begin
              cmd.op    = OP_RD_NODE;
              state_nxt = S_UNLINK;
            end else if (!stat.out_busy) begin
              cmd.op    = OP_RES_ERR;
              cmd.err   = ST_BAD_HANDLE;
              state_nxt = S_IDLE;
            end
          end
          REQ_KTH: begin
            if (!stat.pos_bad) begin
              state_nxt = S_WALK;
            end else if (!stat.out_busy) begin
              cmd.op    = OP_RES_ERR;
              cmd.err   = ST_NOT_FOUND;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (!stat.out_busy) begin
              cmd.op    = OP_RES_ERR;
              cmd.err   = ST_NOT_FOUND;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (stat.free_hit) begin
          cmd.op    = OP_SCAN;
          state_nxt = S_PUSH_W1;
        end else if (!stat.scan_end) begin
          cmd.op = OP_SCAN;
        end else if (!stat.out_busy) begin
          cmd.op    = OP_RES_ERR;
          cmd.err   = ST_FULL;
          state_nxt = S_IDLE;
        end
      end
      S_PUSH_W1: begin
        cmd.op    = OP_PUSH_W1;
        state_nxt = S_PUSH_W2;
      end
      S_PUSH_W2: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_PUSH_W2;
          state_nxt = S_IDLE;
        end
      end
      S_UNLINK: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_UNLINK;
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (stat.cur_null) begin
          if (!stat.out_busy) begin
            cmd.op    = OP_RES_ERR;
            cmd.err   = ST_NOT_FOUND;
            state_nxt = S_IDLE;
          end
        end else if (stat.walk_done) begin
          cmd.op    = OP_VAL_RD;
          state_nxt = S_RES_NODE;
        end else begin
          cmd.op    = OP_WALK_RD;
          state_nxt = S_WALK_ADV;
        end
      end
      S_WALK_ADV: begin
        cmd.op    = OP_WALK_ADV;
        state_nxt = S_WALK;
      end
      S_RES_NODE: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_RES_NODE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

@@ rtl/core/dll_checker.sv @@
// ----------------------------------------------------------------------------
// dll_checker
// Port-level checks for the linked list pool.
// ----------------------------------------------------------------------------
module dll_checker
  import dll_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [5:0]  out_result_handle,
  input logic [31:0] out_result_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_result_handle) && $stable(out_result_value))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_handle == '0
      && out_result_value == '0)
    else $error("error result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_FULL
      || out_status == ST_EMPTY || out_status == ST_NOT_FOUND
      || out_status == ST_BAD_HANDLE)
    else $error("undefined status");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_no_result_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared on the accepting cycle");

endmodule

bind doubly_linked_list_pool dll_checker u_dll_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_result_handle (out_result_handle),
  .out_result_value  (out_result_value)
);
